// File: hdl/phc_pkg.sv
// shared types and constants for the pixel hit clustering block
package phc_pkg;

  localparam int COL_W    = 8;
  localparam int ROW_W    = 10;
  localparam int PH_W     = 12;
  localparam int CHG_W    = 12;
  localparam int SIZE_W   = 7;
  localparam int SUM_W    = 18;
  localparam int CCOL_W   = 12;
  localparam int CROW_W   = 14;
  localparam int GAP_W    = 3;
  localparam int CSUM_W   = 27;
  localparam int RSUM_W   = 28;
  localparam int NUM_W    = 32;
  localparam int DCNT_W   = 5;
  localparam int FRAC_W   = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // register index of the neighbour gap
  localparam logic REG_GAP = 1'b0;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PH_W-1:0]  pulse;
    logic [CHG_W-1:0] charge;
  } hit_t;

  localparam int HIT_W = $bits(hit_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_SEED_DATA,
    S_FIND,
    S_LOAD,
    S_SCAN,
    S_SCAN_DATA,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

// File: hdl/pixel_hit_clustering.sv
// pixel hit clustering: hit store, neighbour search sequencer and serial divider
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | input     | in_valid / in_ready | has_hit hit_col hit_row pulse_height ...
//  out     | output    | out_valid/out_ready | cluster_size pulse_sum charge_sum ...
//  apb     | input     | psel penable pready | paddr pwdata prdata (neighbour gap)
//
// hits load at one item per cycle while idle; the closing item starts the search if the
// event stored hits, and the block is not ready until the last cluster has been taken.
// a store read takes an address state and a data state, while a skipped entry has no
// data state: a find pass repeats while the cluster grows, each expanded member scans
// the store, and a nonzero charge adds 64 divider steps.
// reset is synchronous and clears the hit count, used flags and overflow flag;
// a stalled result holds the block in its emit state until out_ready.
module pixel_hit_clustering #(
  parameter int MAX_HITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         has_hit,
  input  logic [phc_pkg::COL_W-1:0]    hit_col,
  input  logic [phc_pkg::ROW_W-1:0]    hit_row,
  input  logic [phc_pkg::PH_W-1:0]     pulse_height,
  input  logic [phc_pkg::CHG_W-1:0]    hit_charge,
  input  logic                         end_of_event,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [phc_pkg::SIZE_W-1:0]   cluster_size,
  output logic [phc_pkg::SUM_W-1:0]    pulse_sum,
  output logic [phc_pkg::SUM_W-1:0]    charge_sum,
  output logic [phc_pkg::CCOL_W-1:0]   centroid_col,
  output logic [phc_pkg::CROW_W-1:0]   centroid_row,
  output logic                         zero_charge,
  output logic                         hit_overflow,
  output logic                         last_cluster,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [phc_pkg::PADDR_W-1:0]  paddr,
  input  logic [phc_pkg::PDATA_W-1:0]  pwdata,
  output logic [phc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import phc_pkg::*;

  localparam int IW = $clog2(MAX_HITS);
  localparam int CW = $clog2(MAX_HITS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HITS);

  state_t state, state_next;

  logic [GAP_W-1:0]    gap;
  logic [CW-1:0]       count;
  logic [CW-1:0]       used_cnt;
  logic                ovf;
  logic [MAX_HITS-1:0] used;
  logic [MAX_HITS-1:0] member;
  logic [MAX_HITS-1:0] expanded;
  logic [CW-1:0]       seed_ptr;
  logic [CW-1:0]       p_ptr;
  logic [CW-1:0]       i_ptr;
  logic                grew;
  logic [COL_W-1:0]    base_col;
  logic [ROW_W-1:0]    base_row;
  logic [SIZE_W-1:0]   size;
  logic [SUM_W-1:0]    psum;
  logic [SUM_W-1:0]    qsum;
  logic [CSUM_W-1:0]   csum;
  logic [RSUM_W-1:0]   rsum;
  logic [NUM_W-1:0]    div_num;
  logic [SUM_W:0]      div_rem;
  logic [DCNT_W-1:0]   div_cnt;
  logic                div_row;
  logic [CCOL_W-1:0]   col_q;

  logic                accept;
  logic                store_hit;
  logic [CW-1:0]       count_after;
  logic                finish;
  logic [IW-1:0]       rd_addr;
  hit_t                rd_hit;
  hit_t                wr_hit;
  logic                near;
  logic [COL_W-1:0]    dcol;
  logic [ROW_W-1:0]    drow;
  logic [SUM_W:0]      rem_sh;
  logic                rem_ge;
  logic [SUM_W:0]      rem_new;
  logic [NUM_W-1:0]    num_new;
  logic [COL_W+CHG_W-1:0] cprod;
  logic [ROW_W+CHG_W-1:0] rprod;

  assign accept      = in_valid && in_ready;
  assign store_hit   = accept && has_hit && (count < MAX_CNT);
  assign count_after = count + CW'(store_hit);

  // hit store
  assign wr_hit = '{col: hit_col, row: hit_row, pulse: pulse_height, charge: hit_charge};

  phc_ram #(
    .WIDTH(HIT_W),
    .DEPTH(MAX_HITS)
  ) u_store (
    .clk    (clk),
    .wr_en  (store_hit),
    .wr_addr(count[IW-1:0]),
    .wr_data(wr_hit),
    .rd_addr(rd_addr),
    .rd_data(rd_hit)
  );

  // neighbour test against the member being expanded
  assign dcol = (rd_hit.col > base_col) ? rd_hit.col - base_col : base_col - rd_hit.col;
  assign drow = (rd_hit.row > base_row) ? rd_hit.row - base_row : base_row - rd_hit.row;
  assign near = (dcol <= COL_W'(gap)) && (drow <= ROW_W'(gap));

  // charge weighted coordinates of the entry just read
  assign cprod = {{CHG_W{1'b0}}, rd_hit.col} * {{COL_W{1'b0}}, rd_hit.charge};
  assign rprod = {{CHG_W{1'b0}}, rd_hit.row} * {{ROW_W{1'b0}}, rd_hit.charge};

  // one restoring division step
  assign rem_sh  = {div_rem[SUM_W-1:0], div_num[NUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, qsum};
  assign rem_new = rem_ge ? rem_sh - {1'b0, qsum} : rem_sh;
  assign num_new = {div_num[NUM_W-2:0], rem_ge};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and read address
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    rd_addr    = i_ptr[IW-1:0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept && end_of_event) begin
          if (count_after == '0) begin
            finish = 1'b1;
          end else begin
            state_next = S_SEED;
          end
        end
      end
      S_SEED: begin
        rd_addr = seed_ptr[IW-1:0];
        if (seed_ptr == count) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else if (!used[seed_ptr[IW-1:0]]) begin
          state_next = S_SEED_DATA;
        end
      end
      S_SEED_DATA: state_next = S_FIND;
      S_FIND: begin
        rd_addr = p_ptr[IW-1:0];
        if (p_ptr == count) begin
          if (!grew) begin
            state_next = (qsum == '0) ? S_EMIT : S_DIV;
          end
        end else if (member[p_ptr[IW-1:0]] && !expanded[p_ptr[IW-1:0]]) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_SCAN;
      S_SCAN: begin
        if (i_ptr == count) begin
          state_next = S_FIND;
        end else if (!used[i_ptr[IW-1:0]]) begin
          state_next = S_SCAN_DATA;
        end
      end
      S_SCAN_DATA: state_next = S_SCAN;
      S_DIV: begin
        if (div_row && (div_cnt == DCNT_W'(NUM_W - 1))) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (used_cnt == count) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_SEED;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // event control: count, flags, overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      used_cnt <= '0;
      ovf      <= 1'b0;
      used     <= '0;
    end else if (finish) begin
      count    <= '0;
      used_cnt <= '0;
      ovf      <= 1'b0;
      used     <= '0;
    end else begin
      if (store_hit) begin
        count <= count_after;
      end
      if (accept && has_hit && (count == MAX_CNT)) begin
        ovf <= 1'b1;
      end
      if (state == S_SEED_DATA) begin
        used[seed_ptr[IW-1:0]] <= 1'b1;
        used_cnt               <= used_cnt + 1'b1;
      end
      if (state == S_SCAN_DATA && near) begin
        used[i_ptr[IW-1:0]] <= 1'b1;
        used_cnt            <= used_cnt + 1'b1;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= GAP_W'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAP)) begin
      gap <= pwdata[GAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAP) ? PDATA_W'(gap) : '0;

  // search pointers and cluster accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_ptr <= '0;
      p_ptr    <= '0;
      i_ptr    <= '0;
      grew     <= 1'b0;
      member   <= '0;
      expanded <= '0;
    end else begin
      unique case (state)
        S_IDLE: seed_ptr <= '0;
        S_SEED: begin
          if (seed_ptr != count && used[seed_ptr[IW-1:0]]) begin
            seed_ptr <= seed_ptr + 1'b1;
          end
        end
        S_SEED_DATA: begin
          member   <= '0;
          expanded <= '0;
          member[seed_ptr[IW-1:0]] <= 1'b1;
          size  <= SIZE_W'(1);
          psum  <= SUM_W'(rd_hit.pulse);
          qsum  <= SUM_W'(rd_hit.charge);
          csum  <= CSUM_W'(cprod);
          rsum  <= RSUM_W'(rprod);
          p_ptr <= '0;
          grew  <= 1'b0;
        end
        S_FIND: begin
          if (p_ptr == count) begin
            p_ptr <= '0;
            grew  <= 1'b0;
            div_num <= NUM_W'({csum, FRAC_W'(0)});
            div_rem <= '0;
            div_cnt <= '0;
            div_row <= 1'b0;
          end else if (!(member[p_ptr[IW-1:0]] && !expanded[p_ptr[IW-1:0]])) begin
            p_ptr <= p_ptr + 1'b1;
          end
        end
        S_LOAD: begin
          base_col <= rd_hit.col;
          base_row <= rd_hit.row;
          expanded[p_ptr[IW-1:0]] <= 1'b1;
          i_ptr <= '0;
        end
        S_SCAN: begin
          if (i_ptr == count) begin
            p_ptr <= p_ptr + 1'b1;
          end else if (used[i_ptr[IW-1:0]]) begin
            i_ptr <= i_ptr + 1'b1;
          end
        end
        S_SCAN_DATA: begin
          if (near) begin
            member[i_ptr[IW-1:0]] <= 1'b1;
            grew <= 1'b1;
            size <= size + 1'b1;
            psum <= psum + SUM_W'(rd_hit.pulse);
            qsum <= qsum + SUM_W'(rd_hit.charge);
            csum <= csum + CSUM_W'(cprod);
            rsum <= rsum + RSUM_W'(rprod);
          end
          i_ptr <= i_ptr + 1'b1;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(NUM_W - 1) && !div_row) begin
            col_q   <= num_new[CCOL_W-1:0];
            div_num <= NUM_W'({rsum, FRAC_W'(0)});
            div_rem <= '0;
            div_row <= 1'b1;
          end else begin
            div_num <= num_new;
            div_rem <= rem_new;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            seed_ptr <= seed_ptr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_FIND && state_next == S_EMIT) begin
      cluster_size <= size;
      pulse_sum    <= psum;
      charge_sum   <= qsum;
      centroid_col <= '0;
      centroid_row <= '0;
      zero_charge  <= 1'b1;
    end else if (state == S_DIV && state_next == S_EMIT) begin
      cluster_size <= size;
      pulse_sum    <= psum;
      charge_sum   <= qsum;
      centroid_col <= col_q;
      centroid_row <= num_new[CROW_W-1:0];
      zero_charge  <= 1'b0;
    end
  end

  assign out_valid    = (state == S_EMIT);
  assign hit_overflow = ovf;
  assign last_cluster = (used_cnt == count);

  // checks
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while a cluster is pending");

  a_zero_centroid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_charge) |-> (centroid_col == '0 && centroid_row == '0))
    else $error("zero charge cluster with nonzero centroid");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cluster_size != '0)) else $error("empty cluster emitted");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= count) else $error("more hits used than stored");

endmodule

// File: hdl/phc_ram.sv
// generic single-port-write ram with registered read
module phc_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: tb/pixel_hit_clustering_tb.sv
// self-checking testbench for the pixel hit clustering block
`timescale 1ns / 1ps

module pixel_hit_clustering_tb;
  import phc_pkg::*;

  localparam int NHITS = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [PADDR_W-1:0] ADDR_GAP = PADDR_W'(4 * REG_GAP);

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SUM_W-1:0]  psum;
    logic [SUM_W-1:0]  qsum;
    logic [CCOL_W-1:0] ccol;
    logic [CROW_W-1:0] crow;
    logic              zq;
    logic              ovf;
    logic              last;
  } cluster_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic has_hit = 1'b0;
  logic [COL_W-1:0] hit_col = '0;
  logic [ROW_W-1:0] hit_row = '0;
  logic [PH_W-1:0] pulse_height = '0;
  logic [CHG_W-1:0] hit_charge = '0;
  logic end_of_event = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SIZE_W-1:0] cluster_size;
  logic [SUM_W-1:0] pulse_sum;
  logic [SUM_W-1:0] charge_sum;
  logic [CCOL_W-1:0] centroid_col;
  logic [CROW_W-1:0] centroid_row;
  logic zero_charge;
  logic hit_overflow;
  logic last_cluster;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // predictor copy of the block state
  hit_t store_q[NHITS];
  int unsigned stored_n;
  logic ovf_q;
  logic [GAP_W-1:0] gap_q;
  cluster_t clusters_q[$];

  int errors = 0;
  int cycles = 0;
  bit stall_on = 1'b1;

  pixel_hit_clustering i_dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit hits_near(int a, int b);
    int dc, dr;
    dc = int'(store_q[a].col) - int'(store_q[b].col);
    dr = int'(store_q[a].row) - int'(store_q[b].row);
    if (dc < 0) dc = -dc;
    if (dr < 0) dr = -dr;
    return dc <= int'(gap_q) && dr <= int'(gap_q);
  endfunction

  // cluster prediction for one accepted item
  task automatic predict_clusters(hit_t h, bit with_hit, bit eoe);
    logic [NHITS-1:0] used, members;
    bit growing;
    longint unsigned ps, qs, cs, rs;
    int sz, first_new;
    cluster_t c;
    if (with_hit) begin
      if (stored_n < NHITS) begin
        store_q[stored_n] = h;
        stored_n++;
      end else ovf_q = 1'b1;
    end
    if (!eoe) return;
    used = '0;
    first_new = clusters_q.size();
    for (int s = 0; s < stored_n; s++) begin
      if (used[s]) continue;
      members = '0;
      members[s] = 1'b1;
      used[s] = 1'b1;
      do begin
        growing = 1'b0;
        for (int i = 0; i < stored_n; i++) begin
          if (used[i]) continue;
          for (int j = 0; j < stored_n; j++) begin
            if (members[j] && hits_near(i, j)) begin
              members[i] = 1'b1;
              used[i] = 1'b1;
              growing = 1'b1;
              break;
            end
          end
        end
      end while (growing);
      sz = 0; ps = 0; qs = 0; cs = 0; rs = 0;
      for (int i = 0; i < stored_n; i++) begin
        if (!members[i]) continue;
        sz++;
        ps += store_q[i].pulse;
        qs += store_q[i].charge;
        cs += longint'(store_q[i].col) * store_q[i].charge;
        rs += longint'(store_q[i].row) * store_q[i].charge;
      end
      c.size = SIZE_W'(sz);
      c.psum = SUM_W'(ps);
      c.qsum = SUM_W'(qs);
      c.zq = (qs == 0);
      c.ccol = c.zq ? '0 : CCOL_W'((cs * 16) / qs);
      c.crow = c.zq ? '0 : CROW_W'((rs * 16) / qs);
      c.ovf = ovf_q;
      c.last = 1'b0;
      clusters_q = {clusters_q, c};
    end
    if (clusters_q.size() > first_new) clusters_q[clusters_q.size()-1].last = 1'b1;
    stored_n = 0;
    ovf_q = 1'b0;
  endtask

  // result checker with random receiver stalls
  initial begin
    cluster_t e;
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        if (stall_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (clusters_q.size() == 0) begin
          $error("cluster with no expectation waiting");
          errors++;
        end else begin
          e = clusters_q.pop_front();
          if (cluster_size !== e.size) begin
            $error("cluster_size exp %0d got %0d", e.size, cluster_size); errors++;
          end
          if (pulse_sum !== e.psum) begin
            $error("pulse_sum exp %0d got %0d", e.psum, pulse_sum); errors++;
          end
          if (charge_sum !== e.qsum) begin
            $error("charge_sum exp %0d got %0d", e.qsum, charge_sum); errors++;
          end
          if (centroid_col !== e.ccol) begin
            $error("centroid_col exp %0d got %0d", e.ccol, centroid_col); errors++;
          end
          if (centroid_row !== e.crow) begin
            $error("centroid_row exp %0d got %0d", e.crow, centroid_row); errors++;
          end
          if (zero_charge !== e.zq) begin
            $error("zero_charge exp %0d got %0d", e.zq, zero_charge); errors++;
          end
          if (hit_overflow !== e.ovf) begin
            $error("hit_overflow exp %0d got %0d", e.ovf, hit_overflow); errors++;
          end
          if (last_cluster !== e.last) begin
            $error("last_cluster exp %0d got %0d", e.last, last_cluster); errors++;
          end
        end
      end
    end
  end

  // send one item, with an optional random gap ahead of it
  // valid stays high after the item until the next item or an idle period
  task automatic send_item(bit hh, int col, int row, int ph, int q, bit eoe);
    hit_t h;
    int idle;
    if (stall_on && $urandom_range(0, 4) == 0) begin
      idle = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    h.col = COL_W'(col);
    h.row = ROW_W'(row);
    h.pulse = PH_W'(ph);
    h.charge = CHG_W'(q);
    in_valid <= 1'b1;
    has_hit <= hh;
    hit_col <= h.col;
    hit_row <= h.row;
    pulse_height <= h.pulse;
    hit_charge <= h.charge;
    end_of_event <= eoe;
    do @(posedge clk); while (!in_ready);
    predict_clusters(h, hh, eoe);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (clusters_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_gap(int value);
    wait_drained();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_GAP; pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gap_q = GAP_W'(value);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_random_event(int nhits, int spread);
    int c0, r0;
    c0 = $urandom_range(0, 255);
    r0 = $urandom_range(0, 1023);
    for (int k = 0; k < nhits; k++) begin
      send_item(1'b1, (c0 + $urandom_range(0, spread)) % 256,
                (r0 + $urandom_range(0, spread)) % 1024,
                $urandom_range(0, 4095),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 4095),
                k == nhits - 1);
    end
  endtask

  // directed: field extremes, empty events, zero charge
  task automatic test_directed();
    send_item(1'b0, 0, 0, 0, 0, 1'b1);
    send_item(1'b0, 255, 1023, 4095, 4095, 1'b0);
    send_item(1'b1, 0, 0, 0, 0, 1'b1);
    send_item(1'b1, 255, 1023, 4095, 4095, 1'b0);
    send_item(1'b1, 254, 1022, 4095, 4095, 1'b0);
    send_item(1'b1, 0, 0, 4095, 0, 1'b0);
    send_item(1'b1, 1, 1, 0, 0, 1'b1);
    send_item(1'b1, 10, 10, 100, 200, 1'b0);
    send_item(1'b1, 12, 10, 100, 200, 1'b0);
    send_item(1'b1, 11, 11, 100, 200, 1'b0);
    send_item(1'b0, 0, 0, 0, 0, 1'b1);
  endtask

  task automatic test_overflow();
    for (int k = 0; k < NHITS + 3; k++)
      send_item(1'b1, $urandom_range(0, 255), $urandom_range(0, 1023),
                $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0);
    send_item(1'b1, 5, 5, 1, 1, 1'b1);
    wait_drained();
  endtask

  task automatic test_gap_zero();
    write_gap(0);
    send_item(1'b1, 7, 7, 1, 2, 1'b0);
    send_item(1'b1, 7, 7, 3, 4, 1'b0);
    send_item(1'b1, 8, 7, 5, 6, 1'b1);
    write_gap(7);
    send_item(1'b1, 0, 0, 1, 9, 1'b0);
    send_item(1'b1, 7, 7, 1, 9, 1'b0);
    send_item(1'b1, 14, 14, 1, 9, 1'b0);
    send_item(1'b1, 22, 14, 1, 9, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 360) begin
      int n;
      if (sent % 100 < 5) write_gap($urandom_range(0, 7));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0)
        send_item(1'b0, $urandom_range(0, 255), $urandom_range(0, 1023),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  1'($urandom_range(0, 1)));
      send_random_event(n, $urandom_range(1, 12));
      sent += n;
      // hold off until every cluster so far has come out
      if (sent > 200 && sent < 215) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (clusters_q.size() != 0) @(negedge clk);
      end
    end
  endtask

  // last part without any idling
  task automatic test_no_idle();
    wait_drained();
    stall_on = 1'b0;
    write_gap(1);
    for (int k = 0; k < 8; k++) send_random_event($urandom_range(1, 6), 3);
  endtask

  initial begin
    gap_q = GAP_W'(1);
    stored_n = 0;
    ovf_q = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_gap(1);
    test_directed();
    test_overflow();
    test_gap_zero();
    test_random();
    test_no_idle();
    wait_drained();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
